FILE: hw/rtl/mts_pkg.sv
package mts_pkg;

	// Note memory depth; a power of two, so address wrap is a plain truncation.
	localparam int SONG_DEPTH = 256;
	localparam int MEM_AW     = $clog2(SONG_DEPTH);

	localparam int FREQ_W  = 16;
	localparam int DIV_W   = 5;
	localparam int ENTRY_W = DIV_W + FREQ_W;
	localparam int MS_W    = 10;
	localparam int IDX_W   = 9;
	localparam int TR_W    = 5;
	localparam int START_W = 8;
	localparam int SUM_W   = 13;
	localparam int CNT_W   = $clog2(MS_W + 1);

	localparam logic [MS_W-1:0] DVD_MS = MS_W'(1000);
	localparam logic [MS_W-1:0] DVD_TR = MS_W'(16);

	typedef enum logic [2:0] {
		OP_TICK  = 3'd0,
		OP_PLAY  = 3'd1,
		OP_STOP  = 3'd2,
		OP_PAUSE = 3'd3,
		OP_LOAD  = 3'd4
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_DIV_MS,
		ST_DIV_TR,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic              start;
		logic [MS_W-1:0]   dividend;
		logic [DIV_W-1:0]  divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [MS_W-1:0]   quotient;
	} div_rsp_t;

	// Address wrap modulo SONG_DEPTH.
	function automatic logic [MEM_AW-1:0] mem_addr(input logic [SUM_W-1:0] a);
		return a[MEM_AW-1:0];
	endfunction

endpackage

FILE: hw/rtl/melody_tone_sequencer.sv
// Channel   Dir  Handshake                      Payload
// s_axis    in   s_axis_tvalid/s_axis_tready    tuser: operation; tdata: song/entry args
// m_axis    out  m_axis_tvalid/m_axis_tready    tdata: tone_frequency, tone_duration_ms
//
// Play, stop, pause, load and ticks that emit no note complete in the accept cycle.
// A tick that emits a note goes through one note memory read, the shared divider for
// 1000/divisor, the divider again for 16/divisor, then one emit step.
// s_axis_tready is low while a note is being computed, longer if the emit step stalls.
// A finished note sits in the output register; the next item is accepted meanwhile,
// and a following note waits in its emit step until the register frees up.
// arst_n clears all control state; the note memory is undefined until loaded.
module melody_tone_sequencer
	import mts_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [2:0]  s_axis_tuser,   // [2:0] operation
	input  logic [47:0] s_axis_tdata,   // [7:0] song_start, [16:8] song_length,
	                                    // [24:17] entry_address, [40:25] entry_frequency,
	                                    // [45:41] entry_divisor, [47:46] zero
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata    // [15:0] tone_frequency, [25:16] tone_duration_ms,
	                                    // [31:26] zero
);

	// Input fields
	op_t                op;
	logic [START_W-1:0] song_start;
	logic [IDX_W-1:0]   song_length;
	logic [START_W-1:0] entry_address;
	logic [FREQ_W-1:0]  entry_frequency;
	logic [DIV_W-1:0]   entry_divisor;

	assign op              = op_t'(s_axis_tuser);
	assign song_start      = s_axis_tdata[7:0];
	assign song_length     = s_axis_tdata[16:8];
	assign entry_address   = s_axis_tdata[24:17];
	assign entry_frequency = s_axis_tdata[40:25];
	assign entry_divisor   = s_axis_tdata[45:41];

	// Player state
	state_t             state_q, state_nxt;
	logic               playing_q;
	logic [1:0]         prescale_q;
	logic [IDX_W-1:0]   note_idx_q;
	logic [TR_W-1:0]    tr_q;
	logic [START_W-1:0] cur_start_q;
	logic [IDX_W-1:0]   cur_len_q;

	// Note being worked on
	logic [FREQ_W-1:0]  freq_q;
	logic [DIV_W-1:0]   div_q;
	logic [MS_W-1:0]    ms_q;

	// Output register
	logic               out_valid_q;
	logic [FREQ_W-1:0]  out_freq_q;
	logic [MS_W-1:0]    out_ms_q;

	logic               s_acc;
	logic [1:0]         presc_nxt;
	logic               wrap;
	logic [IDX_W-1:0]   idx_eff;
	logic [TR_W-1:0]    tr_eff;
	logic               act;
	logic               emit;
	logic               out_free;

	logic               ram_we;
	logic [MEM_AW-1:0]  ram_waddr;
	logic [MEM_AW-1:0]  ram_raddr;
	logic [ENTRY_W-1:0] ram_wdata;
	logic [ENTRY_W-1:0] ram_rdata;
	logic [DIV_W-1:0]   rd_div;

	div_req_t           div_req;
	div_rsp_t           div_rsp;

	assign s_acc     = s_axis_tvalid && s_axis_tready;
	assign presc_nxt = prescale_q + 2'd1;
	// Running past the song end restarts it and drops any remaining time.
	assign wrap      = note_idx_q >= cur_len_q;
	assign idx_eff   = wrap ? '0 : note_idx_q;
	assign tr_eff    = wrap ? '0 : tr_q;
	assign act       = s_acc && (op == OP_TICK) && playing_q && (presc_nxt == 2'd0);
	assign emit      = act && (tr_eff == '0);
	assign out_free  = !out_valid_q || m_axis_tready;

	// Note memory: entry is {divisor, frequency}
	assign ram_we    = s_acc && (op == OP_LOAD);
	assign ram_waddr = mem_addr(SUM_W'(entry_address));
	assign ram_wdata = {entry_divisor, entry_frequency};
	assign ram_raddr = mem_addr(SUM_W'(cur_start_q) + SUM_W'(idx_eff));
	// A zero divisor plays as a whole second.
	assign rd_div    = (ram_rdata[ENTRY_W-1:FREQ_W] == '0) ? DIV_W'(1)
	                                                       : ram_rdata[ENTRY_W-1:FREQ_W];

	mts_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(SONG_DEPTH)
	) u_note_mem (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	mts_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Sequencer: next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE:   if (emit) state_nxt = ST_READ;
			ST_READ:   state_nxt = ST_DIV_MS;
			ST_DIV_MS: if (div_rsp.done) state_nxt = ST_DIV_TR;
			ST_DIV_TR: if (div_rsp.done) state_nxt = ST_EMIT;
			ST_EMIT:   if (out_free) state_nxt = ST_IDLE;
			default:   state_nxt = ST_IDLE;
		endcase
	end

	// Sequencer: outputs
	always_comb begin
		s_axis_tready    = 1'b0;
		div_req.start    = 1'b0;
		div_req.dividend = DVD_TR;
		div_req.divisor  = div_q;
		case (state_q)
			ST_IDLE: begin
				s_axis_tready = 1'b1;
			end
			ST_READ: begin
				div_req.start    = 1'b1;
				div_req.dividend = DVD_MS;
				div_req.divisor  = rd_div;
			end
			ST_DIV_MS: begin
				div_req.start = div_rsp.done;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			playing_q   <= 1'b0;
			prescale_q  <= '0;
			note_idx_q  <= '0;
			tr_q        <= '0;
			cur_start_q <= '0;
			cur_len_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (s_acc) begin
				case (op)
					OP_PLAY: begin
						note_idx_q  <= '0;
						cur_start_q <= song_start;
						cur_len_q   <= song_length;
						playing_q   <= 1'b1;
					end
					OP_STOP: begin
						note_idx_q <= '0;
						playing_q  <= 1'b0;
					end
					OP_PAUSE: begin
						playing_q <= !playing_q;
					end
					OP_TICK: begin
						if (playing_q) begin
							prescale_q <= presc_nxt;
							if (presc_nxt == 2'd0) begin
								if (tr_eff != '0) begin
									tr_q       <= tr_eff - 1'b1;
									note_idx_q <= idx_eff;
								end else begin
									note_idx_q <= idx_eff + 1'b1;
								end
							end
						end
					end
					default: begin
					end
				endcase
			end
			// time remaining for the new note: 16 / divisor
			if (state_q == ST_DIV_TR && div_rsp.done) begin
				tr_q <= div_rsp.quotient[TR_W-1:0];
			end
			if (out_valid_q && m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == ST_EMIT && out_free) begin
				out_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_READ) begin
			freq_q <= ram_rdata[FREQ_W-1:0];
			div_q  <= rd_div;
		end
		if (state_q == ST_DIV_MS && div_rsp.done) begin
			ms_q <= div_rsp.quotient;
		end
		if (state_q == ST_EMIT && out_free) begin
			out_freq_q <= freq_q;
			out_ms_q   <= ms_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {6'd0, out_ms_q, out_freq_q};

`ifndef SYNTHESIS
	a_tr_range: assert property (@(posedge clk) disable iff (!arst_n)
		tr_q <= TR_W'(16))
		else $error("time remaining above 16");

	a_div_to_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV_TR && div_rsp.done) |=> (state_q == ST_EMIT))
		else $error("divider finish did not lead to emit");

	a_load_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_EMIT))
		else $error("output loaded outside emit step");

	a_prescale_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_acc && op == OP_TICK && playing_q) |=> $stable(prescale_q))
		else $error("prescaler moved without a playing tick");
`endif

endmodule

FILE: hw/rtl/mts_ram.sv
module mts_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: hw/rtl/mts_div.sv
// Restoring divider, one quotient bit per cycle.
module mts_div
	import mts_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic [MS_W-1:0]  work_q;   // dividend shifts out the top, quotient in the bottom
	logic [DIV_W-1:0] rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             done_q;
	logic [DIV_W:0]   trial;
	logic [DIV_W:0]   diff;
	logic             fits;

	assign trial = {rem_q, work_q[MS_W-1]};
	assign diff  = trial - {1'b0, req.divisor};
	assign fits  = trial >= {1'b0, req.divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (req.start) begin
			cnt_q  <= CNT_W'(MS_W);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q  <= cnt_q - 1'b1;
			done_q <= (cnt_q == CNT_W'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			work_q <= req.dividend;
			rem_q  <= '0;
		end else if (cnt_q != '0) begin
			work_q <= {work_q[MS_W-2:0], fits};
			rem_q  <= fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = work_q;

endmodule

FILE: sim/mts_tone_checker.sv
// Watches both stream channels, tracks the player state itself and checks each
// tone against the oldest one it predicted.
module mts_tone_checker
	import mts_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [2:0]  s_axis_tuser,    // [2:0] operation
	input  logic [47:0] s_axis_tdata,    // [7:0] song_start, [16:8] song_length,
	                                     // [24:17] entry_address, [40:25] entry_frequency,
	                                     // [45:41] entry_divisor, [47:46] zero
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [31:0] m_axis_tdata,    // [15:0] tone_frequency, [25:16] tone_duration_ms
	output int          mismatch_count,
	output int          tones_owed
);

	localparam int MS_PER_SEC    = 1000;
	localparam int TICKS_PER_SEC = 16;

	typedef struct packed {
		logic [FREQ_W-1:0] freq;
		logic [MS_W-1:0]   ms;
	} tone_t;

	tone_t              tone_queue[$];
	logic [ENTRY_W-1:0] note_mem [SONG_DEPTH];
	logic               playing;
	logic [1:0]         prescale;
	logic [IDX_W-1:0]   note_idx;
	logic [TR_W-1:0]    time_left;
	logic [START_W-1:0] song_base;
	logic [IDX_W-1:0]   song_len;
	int                 errors = 0;

	function automatic void advance_player(input logic [2:0] op, input logic [47:0] args);
		logic [IDX_W:0]     addr_sum;
		logic [ENTRY_W-1:0] entry;
		int                 div;
		tone_t              tone;
		case (op)
		OP_PLAY: begin
			note_idx  = '0;
			song_base = args[7:0];
			song_len  = args[16:8];
			playing   = 1'b1;
		end
		OP_STOP: begin
			note_idx = '0;
			playing  = 1'b0;
		end
		OP_PAUSE: playing = !playing;
		OP_LOAD: note_mem[args[24:17]] = {args[45:41], args[40:25]};
		OP_TICK: if (playing) begin
			prescale = prescale + 2'd1;
			if (prescale == 2'd0) begin
				if (note_idx >= song_len) begin
					note_idx  = '0;
					time_left = '0;
				end
				if (time_left != '0) begin
					time_left = time_left - 1'b1;
				end else begin
					// song address wraps at the memory depth
					addr_sum  = song_base + note_idx;
					entry     = note_mem[addr_sum[MEM_AW-1:0]];
					div       = (entry[ENTRY_W-1:FREQ_W] == '0) ? 1 :
					            int'(entry[ENTRY_W-1:FREQ_W]);
					tone.freq = entry[FREQ_W-1:0];
					tone.ms   = MS_W'(MS_PER_SEC / div);
					time_left = TR_W'(TICKS_PER_SEC / div);
					note_idx  = note_idx + 1'b1;
					tone_queue.push_back(tone);
				end
			end
		end
		default: ;
		endcase
	endfunction

	always @(posedge clk) begin
		tone_t want;
		if (!arst_n) begin
			playing   = 1'b0;
			prescale  = '0;
			note_idx  = '0;
			time_left = '0;
			song_base = '0;
			song_len  = '0;
			tone_queue.delete();
		end else begin
			// results leaving now were predicted earlier; check before predicting
			if (m_axis_tvalid && m_axis_tready) begin
				if (tone_queue.size() == 0) begin
					$display("%0t: unexpected tone, freq %0d ms %0d", $time,
					         m_axis_tdata[15:0], m_axis_tdata[25:16]);
					errors++;
				end else begin
					want = tone_queue.pop_front();
					if (want.freq !== m_axis_tdata[15:0]) begin
						$display("%0t: tone_frequency expected %0d actual %0d", $time,
						         want.freq, m_axis_tdata[15:0]);
						errors++;
					end
					if (want.ms !== m_axis_tdata[25:16]) begin
						$display("%0t: tone_duration_ms expected %0d actual %0d", $time,
						         want.ms, m_axis_tdata[25:16]);
						errors++;
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				advance_player(s_axis_tuser, s_axis_tdata);
		end
		mismatch_count <= errors;
		tones_owed     <= tone_queue.size();
	end

endmodule

FILE: sim/tb.sv
// Stimulus and verdict for the melody sequencer. Checking is done in the
// tone checker next to the dut; this module drives both channels and runs a watchdog.
module tb;
	import mts_pkg::*;

	localparam int ITEM_TARGET    = 1450;
	localparam int DRAIN_CYCLES   = 40;   // more than one full note computation
	localparam int WATCHDOG_LIMIT = 2000; // idle cycles

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [2:0]  s_axis_tuser;    // [2:0] operation
	logic [47:0] s_axis_tdata;    // [7:0] song_start, [16:8] song_length,
	                              // [24:17] entry_address, [40:25] entry_frequency,
	                              // [45:41] entry_divisor, [47:46] zero
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [31:0] m_axis_tdata;    // [15:0] tone_frequency, [25:16] tone_duration_ms
	int          mismatch_count;
	int          tones_owed;

	int          items_sent;
	logic        src_burst;       // sender runs with no gaps while set
	logic        sink_burst;      // receiver never stalls while set

	melody_tone_sequencer dut (.*);
	mts_tone_checker      tone_chk (.*);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic logic [47:0] note_args(input logic [7:0] start, input logic [8:0] len,
	                                          input logic [7:0] addr, input logic [15:0] freq,
	                                          input logic [4:0] div);
		return {2'b00, div, freq, addr, len, start};
	endfunction

	// Mostly ticks, so songs actually get played; a few unknown codes as noise.
	function automatic logic [2:0] random_op();
		int r;
		r = $urandom_range(0, 99);
		if (r < 62) return OP_TICK;
		if (r < 70) return OP_PLAY;
		if (r < 74) return OP_STOP;
		if (r < 79) return OP_PAUSE;
		if (r < 96) return OP_LOAD;
		return 3'($urandom_range(5, 7));
	endfunction

	// Top two bits zero, the rest random; short songs so the index wrap is hit often,
	// and mostly large divisors so tones come out on most acting ticks.
	function automatic logic [47:0] random_args(input logic [2:0] op);
		logic [47:0] args;
		args = {2'b00, 14'($urandom), 32'($urandom)};
		case (op)
		OP_PLAY: begin
			case ($urandom_range(0, 9))
			0: args[16:8] = '0;
			1: args[16:8] = 9'd256;
			2, 3: args[16:8] = 9'($urandom);
			default: args[16:8] = 9'($urandom_range(1, 8));
			endcase
		end
		OP_LOAD: begin
			if ($urandom_range(0, 3) != 0)
				args[45:41] = 5'($urandom_range(12, 31));
			case ($urandom_range(0, 7))
			0: args[40:25] = '0;
			1: args[40:25] = '1;
			default: ;
			endcase
		end
		default: ;
		endcase
		return args;
	endfunction

	// One transaction on the input channel, after a random gap.
	// tvalid stays up across back-to-back items.
	task automatic send_item(input logic [2:0] op, input logic [47:0] args);
		int gap;
		gap = src_burst ? 0 : $urandom_range(0, 15);
		@(negedge clk);
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= op;
		s_axis_tdata  <= args;
		@(posedge clk);
		while (!(s_axis_tvalid && s_axis_tready)) @(posedge clk);
		if (op <= OP_LOAD)
			items_sent++;
	endtask

	// Hold the input channel idle until every predicted tone has come out.
	task automatic wait_for_tones();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (tones_owed != 0) @(negedge clk);
	endtask

	// Output side: random stall before each transaction, with stall-free stretches.
	initial begin
		int stall;
		int served;
		m_axis_tready = 1'b0;
		sink_burst = 1'b0;
		served = 0;
		forever begin
			if (served % 40 == 0)
				sink_burst = ($urandom_range(0, 3) == 0);
			stall = sink_burst ? 0 : $urandom_range(0, 15);
			@(negedge clk);
			if (stall != 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_axis_tready <= 1'b1;
			@(posedge clk);
			while (!(m_axis_tvalid && m_axis_tready)) @(posedge clk);
			served++;
		end
	end

	// Watchdog: too long with no transaction on either side means a hang.
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				quiet = 0;
			else
				quiet++;
		end
		$display("tb NOT OK");
		$finish;
	end

	initial begin
		logic [2:0]  op;
		logic [47:0] args;
		logic        drained_once;
		s_axis_tvalid = 1'b0;
		s_axis_tuser  = OP_TICK;
		s_axis_tdata  = '0;
		src_burst     = 1'b0;
		items_sent    = 0;
		drained_once  = 1'b0;
		arst_n        = 1'b0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		// Directed part. Only loaded entries are ever played: the memory has
		// no reset value, and reading an unloaded entry is not a legal case.
		send_item(OP_LOAD, note_args(8'd0, 9'd0, 8'd0, 16'd0, 5'd17));        // rest, no hold
		send_item(OP_LOAD, note_args(8'd0, 9'd0, 8'd255, 16'hFFFF, 5'd31));   // divisor max
		send_item(OP_LOAD, note_args(8'd0, 9'd0, 8'd2, 16'h8000, 5'd0));      // divisor zero
		send_item(3'd7, 48'h3FFF_FFFF_FFFF);                                   // unknown op
		send_item(3'd5, '0);
		send_item(OP_TICK, '0);                    // stopped: tick does nothing
		// resume straight out of reset: song at 0 with length zero,
		// so entry 0 plays on every acting tick
		send_item(OP_PAUSE, '0);
		repeat (8) send_item(OP_TICK, '0);
		send_item(OP_STOP, '0);
		// song runs off the top of memory and wraps to address 0
		send_item(OP_PLAY, note_args(8'd255, 9'd2, 8'd0, 16'd0, 5'd0));
		repeat (8) send_item(OP_TICK, '0);
		send_item(OP_PLAY, note_args(8'd2, 9'd1, 8'd0, 16'd0, 5'd0));
		repeat (4) send_item(OP_TICK, '0);
		send_item(OP_STOP, '0);
		wait_for_tones();

		// Fill the whole memory so any song is legal from here on.
		for (int a = 0; a < SONG_DEPTH; a++) begin
			if (a % 50 == 0)
				src_burst = ($urandom_range(0, 3) == 0);
			args = random_args(OP_LOAD);
			args[24:17] = 8'(a);
			send_item(OP_LOAD, args);
		end

		// Random mix of play/stop/pause/load and unknown codes, mostly ticks.
		while (items_sent < ITEM_TARGET) begin
			if (items_sent % 50 == 0)
				src_burst = ($urandom_range(0, 3) == 0);
			if (!drained_once && items_sent >= 800) begin
				wait_for_tones();
				drained_once = 1'b1;
			end
			op = random_op();
			send_item(op, random_args(op));
		end

		wait_for_tones();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && tones_owed == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

endmodule

FILE: melody_tone_sequencer.f
hw/rtl/mts_pkg.sv
hw/rtl/mts_ram.sv
hw/rtl/mts_div.sv
hw/rtl/melody_tone_sequencer.sv
sim/mts_tone_checker.sv
sim/tb.sv
